// ===== rtl/core/bol_pkg.sv =====
// ----------------------------------------------------------------------------
// bol_pkg: shared types and constants of the bounded ordered list
// Command codes, status codes and the per-command control group that the
// top level hands to every cell of the chain.
// ----------------------------------------------------------------------------
package bol_pkg;

    localparam int VAL_W    = 32;
    localparam int CMD_W    = 4;
    localparam int POS_W    = 5;
    localparam int FIDX_W   = 4;
    localparam int CNT_W    = 5;
    localparam int STAT_W   = 2;
    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_INS_BACK  = 4'd0,
        CMD_INS_FRONT = 4'd1,
        CMD_INS_AT    = 4'd2,
        CMD_REM_BACK  = 4'd3,
        CMD_REM_FRONT = 4'd4,
        CMD_REM_AT    = 4'd5,
        CMD_MEMBER    = 4'd6,
        CMD_READ      = 4'd7,
        CMD_FIND      = 4'd8,
        CMD_LENGTH    = 4'd9,
        CMD_CLEAR     = 4'd10
    } cmd_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    // Control group broadcast to all cells for one transaction
    typedef struct packed {
        logic load;      // transaction accepted this cycle
        logic ins;       // shift up and insert at idx
        logic rem;       // shift down from idx
        logic match_en;  // compare stored values against the search value
        logic rd_en;     // tap the value at idx
    } cell_ctrl_t;

endpackage

// ===== rtl/core/bol_cell.sv =====
// ----------------------------------------------------------------------------
// bol_cell: one slot of the ordered list chain
// Holds one value, takes its left or right neighbor on insert or remove,
// and registers its own search hit and read tap for the result stage.
// ----------------------------------------------------------------------------
module bol_cell #(
    parameter int IDX = 0,
    parameter int IW  = 4,
    parameter int FW  = 5
) (
    input  logic                         aclk,
    input  bol_pkg::cell_ctrl_t          ctrl,
    input  logic [IW-1:0]                idx,
    input  logic [FW-1:0]                fill,
    input  logic [bol_pkg::VAL_W-1:0]    value,
    input  logic [bol_pkg::VAL_W-1:0]    left_val,
    input  logic [bol_pkg::VAL_W-1:0]    right_val,
    output logic [bol_pkg::VAL_W-1:0]    slot_val,
    output logic                         match,
    output logic [bol_pkg::VAL_W-1:0]    tap
);

    logic [bol_pkg::VAL_W-1:0] slot_reg, slot_next;
    logic                      match_reg, match_next;
    logic [bol_pkg::VAL_W-1:0] tap_reg, tap_next;
    logic                      here, above, occupied;

    assign here     = (idx == IW'(IDX));
    assign above    = (IW'(IDX) > idx);
    assign occupied = (FW'(IDX) < fill);

    // Select the new slot content: shift up, insert, shift down or hold
    always_comb begin
        slot_next = slot_reg;
        if (ctrl.ins && above) begin
            slot_next = left_val;
        end else if (ctrl.ins && here) begin
            slot_next = value;
        end else if (ctrl.rem && (above || here)) begin
            slot_next = right_val;
        end
    end

    // Hit and tap come from the contents before this transaction
    assign match_next = ctrl.match_en && occupied && (slot_reg == value);
    assign tap_next   = (ctrl.rd_en && here) ? slot_reg : '0;

    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            slot_reg  <= slot_next;
            match_reg <= match_next;
            tap_reg   <= tap_next;
        end
    end

    assign slot_val = slot_reg;
    assign match    = match_reg;
    assign tap      = tap_reg;

endmodule

// ===== rtl/core/bounded_ordered_list_core.sv =====
// ----------------------------------------------------------------------------
// bounded_ordered_list_core: ordered list of signed 32-bit values
// Chain of CAPACITY cells with insert, remove, read, search, length, clear.
// ----------------------------------------------------------------------------
// The block takes one command transaction per cycle while s_tready is high
// and returns exactly one result per command. In the accept cycle the fill
// count is checked, every cell shifts toward its neighbor as the command
// asks, and each cell registers its own search hit and read tap; when the
// staged transaction moves on, those per-cell flags are combined (OR of the
// taps, first-hit priority over the cells) into the
// output register. An output register and a result stage stand between the
// sides, so a stalled result side stops input only once both are full.
// Stored values are not cleared at reset; the fill count is.
module bounded_ordered_list_core #(
    parameter int CAPACITY = 16
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [3:0] cmd, [35:4] item_value, [40:36] position, [47:41] zero
    input  logic [bol_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] result_value, [32] found, [36:33] found_index, [41:37] count,
    // [43:42] status, [47:44] zero
    output logic [bol_pkg::M_DATA_W-1:0]    m_tdata
);

    localparam int FW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);
    localparam int CW = (FW > bol_pkg::POS_W) ? FW : bol_pkg::POS_W;

    // Input fields
    logic [bol_pkg::CMD_W-1:0] in_cmd;
    logic [bol_pkg::VAL_W-1:0] in_value;
    logic [bol_pkg::POS_W-1:0] in_pos;
    assign in_cmd   = s_tdata[3:0];
    assign in_value = s_tdata[35:4];
    assign in_pos   = s_tdata[40:36];

    logic accept, move;
    logic [FW-1:0] fill_reg, fill_next;
    logic          stg_valid_reg;
    bol_pkg::status_t stg_status_reg, status_c;
    logic [FW-1:0] stg_fill_reg;
    logic          stg_find_reg, find_c;

    logic                     m_tvalid_reg;
    logic [bol_pkg::VAL_W-1:0] m_value_reg;
    logic                      m_found_reg;
    logic [bol_pkg::FIDX_W-1:0] m_fidx_reg;
    logic [bol_pkg::CNT_W-1:0] m_count_reg;
    bol_pkg::status_t          m_status_reg;

    bol_pkg::cell_ctrl_t ctrl;
    logic [IW-1:0]       idx_c;
    logic [CW-1:0]       pos_c, fill_c;
    logic                full;

    assign move     = stg_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !stg_valid_reg || move;
    assign accept   = s_tvalid && s_tready;

    assign pos_c  = CW'(in_pos);
    assign fill_c = CW'(fill_reg);
    assign full   = (fill_reg == FW'(CAPACITY));

    // Decode the command against the current fill count
    always_comb begin
        ctrl      = '0;
        ctrl.load = accept;
        idx_c     = '0;
        fill_next = fill_reg;
        status_c  = bol_pkg::ST_OK;
        find_c    = 1'b0;
        case (bol_pkg::cmd_t'(in_cmd))
            bol_pkg::CMD_INS_BACK: begin
                if (full) begin
                    status_c = bol_pkg::ST_FULL;
                end else begin
                    ctrl.ins  = 1'b1;
                    idx_c     = IW'(fill_reg);
                    fill_next = fill_reg + 1'b1;
                end
            end
            bol_pkg::CMD_INS_FRONT: begin
                if (full) begin
                    status_c = bol_pkg::ST_FULL;
                end else begin
                    ctrl.ins  = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            bol_pkg::CMD_INS_AT: begin
                if (full) begin
                    status_c = bol_pkg::ST_FULL;
                end else if (pos_c > fill_c) begin
                    status_c = bol_pkg::ST_RANGE;
                end else begin
                    ctrl.ins  = 1'b1;
                    idx_c     = pos_c[IW-1:0];
                    fill_next = fill_reg + 1'b1;
                end
            end
            bol_pkg::CMD_REM_BACK: begin
                if (fill_reg == '0) begin
                    status_c = bol_pkg::ST_RANGE;
                end else begin
                    ctrl.rem   = 1'b1;
                    ctrl.rd_en = 1'b1;
                    idx_c      = IW'(fill_reg - 1'b1);
                    fill_next  = fill_reg - 1'b1;
                end
            end
            bol_pkg::CMD_REM_FRONT: begin
                if (fill_reg == '0) begin
                    status_c = bol_pkg::ST_RANGE;
                end else begin
                    ctrl.rem   = 1'b1;
                    ctrl.rd_en = 1'b1;
                    fill_next  = fill_reg - 1'b1;
                end
            end
            bol_pkg::CMD_REM_AT: begin
                if (pos_c >= fill_c) begin
                    status_c = bol_pkg::ST_RANGE;
                end else begin
                    ctrl.rem   = 1'b1;
                    ctrl.rd_en = 1'b1;
                    idx_c      = pos_c[IW-1:0];
                    fill_next  = fill_reg - 1'b1;
                end
            end
            bol_pkg::CMD_MEMBER: begin
                ctrl.match_en = 1'b1;
            end
            bol_pkg::CMD_READ: begin
                if (pos_c >= fill_c) begin
                    status_c = bol_pkg::ST_RANGE;
                end else begin
                    ctrl.rd_en = 1'b1;
                    idx_c      = pos_c[IW-1:0];
                end
            end
            bol_pkg::CMD_FIND: begin
                ctrl.match_en = 1'b1;
                find_c        = 1'b1;
            end
            bol_pkg::CMD_LENGTH: begin
                fill_next = fill_reg;
            end
            bol_pkg::CMD_CLEAR: begin
                fill_next = '0;
            end
            default: begin
                fill_next = fill_reg;
            end
        endcase
    end

    // Cell chain
    logic [bol_pkg::VAL_W-1:0] slot_q [CAPACITY];
    logic [bol_pkg::VAL_W-1:0] tap_q  [CAPACITY];
    logic [CAPACITY-1:0]       match_q;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [bol_pkg::VAL_W-1:0] left_val, right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_mid_l
            assign left_val = slot_q[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = slot_q[i];
        end else begin : g_mid_r
            assign right_val = slot_q[i+1];
        end
        bol_cell #(
            .IDX (i),
            .IW  (IW),
            .FW  (FW)
        ) u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .idx       (idx_c),
            .fill      (fill_reg),
            .value     (in_value),
            .left_val  (left_val),
            .right_val (right_val),
            .slot_val  (slot_q[i]),
            .match     (match_q[i]),
            .tap       (tap_q[i])
        );
    end

    // Combine the per-cell flags of the staged transaction
    logic [bol_pkg::VAL_W-1:0] tap_or;
    logic [IW-1:0]             first_hit;
    always_comb begin
        tap_or    = '0;
        first_hit = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            tap_or = tap_or | tap_q[i];
        end
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (match_q[i]) begin
                first_hit = IW'(i);
            end
        end
    end

    // Fill count and result stage control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            stg_valid_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                fill_reg <= fill_next;
            end
            if (accept) begin
                stg_valid_reg <= 1'b1;
            end else if (move) begin
                stg_valid_reg <= 1'b0;
            end
            if (move) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Stage and output payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            stg_status_reg <= status_c;
            stg_fill_reg   <= fill_next;
            stg_find_reg   <= find_c;
        end
        if (move) begin
            m_value_reg  <= tap_or;
            m_found_reg  <= |match_q;
            m_fidx_reg   <= (stg_find_reg && (|match_q)) ?
                            bol_pkg::FIDX_W'(first_hit) : '0;
            m_count_reg  <= bol_pkg::CNT_W'(stg_fill_reg);
            m_status_reg <= stg_status_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {4'b0, m_status_reg, m_count_reg, m_fidx_reg, m_found_reg, m_value_reg};

    // Fill count never passes the capacity
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= FW'(CAPACITY))
        else $error("fill count above capacity");

    // A refused insert leaves a full list full
    a_full_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && full && (in_cmd == bol_pkg::CMD_INS_BACK ||
            in_cmd == bol_pkg::CMD_INS_FRONT || in_cmd == bol_pkg::CMD_INS_AT)
        |=> fill_reg == FW'(CAPACITY))
        else $error("refused insert changed fill count");

    // A refused command taps no value for a staged transaction
    a_one_tap: assert property (@(posedge aclk) disable iff (!aresetn)
        stg_valid_reg && stg_status_reg != bol_pkg::ST_OK |-> tap_or == '0)
        else $error("refused command produced a value");

    // A found result always carries ok status
    a_found_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid_reg && m_found_reg |-> m_status_reg == bol_pkg::ST_OK)
        else $error("found flag with error status");

endmodule
